/* hdl/imu_fs_pkg.sv */
package imu_fs_pkg;

    localparam int FRAME_BYTES = 50;

    localparam logic [7:0] PRE_A = 8'hFA;
    localparam logic [7:0] PRE_B = 8'hFF;

    localparam logic [7:0] OFF_EULER = 8'd7;
    localparam logic [7:0] OFF_ACCEL = 8'd22;
    localparam logic [7:0] OFF_RATE  = 8'd37;

    localparam int NUM_WORDS = 9;
    localparam logic [3:0] NO_SLOT = 4'd9;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    // 57.29578 as an IEEE single: significand with hidden bit, exponent 5.
    localparam logic [23:0] RATE_K = 24'hE52EE1;
    // Result exponent field minus one equals lead + input exponent - RATE_EXP_ADJ.
    localparam logic [9:0] RATE_EXP_ADJ = 10'd42;
    // Right shift of the product that lands on the smallest subnormal step.
    localparam logic [4:0] RATE_SUB_SHIFT = 5'd18;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PRE     = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic        bad;
        logic [15:0] errors;
    } frame_meta_t;

    function automatic logic [3:0] word_slot(input logic [7:0] pos);
        logic [3:0] slot;
        slot = NO_SLOT;
        if (pos >= OFF_EULER && pos < OFF_EULER + 8'd12)
            slot = 4'(8'(pos - OFF_EULER) >> 2);
        else if (pos >= OFF_ACCEL && pos < OFF_ACCEL + 8'd12)
            slot = 4'd3 + 4'(8'(pos - OFF_ACCEL) >> 2);
        else if (pos >= OFF_RATE && pos < OFF_RATE + 8'd12)
            slot = 4'd6 + 4'(8'(pos - OFF_RATE) >> 2);
        return slot;
    endfunction

endpackage

/* hdl/imu_frame_sync_and_extract_core.sv */
// Frame parser for a serial inertial-sensor byte stream.
// Input channel: one byte per item on rx_byte, taken at a clock edge where
// in_valid is high and in_stall is low. The block hunts for the preamble
// 0xFA 0xFF, then collects a fixed-length frame and checks its 8-bit sum.
// Output channel: one item per frame (out_valid/out_stall) carrying nine
// IEEE single words (Euler angles, accelerations, scaled rates), the frame
// status and the saturating checksum error count. A bad frame gives zeros.
// Throughput: one byte per cycle while in_stall is low. After the frame's last
// byte is taken, the result passes through the frame register, then the rate
// multiplier product register, then the output register.
// When the receiver stalls, the result holds in the output register and
// bytes keep flowing; only the last byte of the next frame waits, held by
// in_stall, until the earlier result has been taken.
// Reset puts the parser back to hunting and clears the error count and
// all valid flags.
module imu_frame_sync_and_extract_core
    import imu_fs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pitch_bits,
    output logic [31:0] roll_bits,
    output logic [31:0] yaw_bits,
    output logic [31:0] accel_x_bits,
    output logic [31:0] accel_y_bits,
    output logic [31:0] accel_z_bits,
    output logic [31:0] rate_x_bits,
    output logic [31:0] rate_y_bits,
    output logic [31:0] rate_z_bits,
    output logic        frame_status,
    output logic [15:0] checksum_errors
);

    logic        accept, at_last, busy;
    logic        frame_valid;
    frame_meta_t frame_meta;
    word_t       words [NUM_WORDS];
    word_t       rx_in, ry_in, rz_in, rx_out, ry_out, rz_out;

    logic        mul_valid_reg, mul_valid_next;
    frame_meta_t mul_meta_reg;
    logic        out_valid_reg, out_valid_next;
    word_t       val_reg [NUM_WORDS];
    word_t       val_next [NUM_WORDS];
    logic        status_reg;
    logic [15:0] errors_reg;

    assign busy     = frame_valid | mul_valid_reg | out_valid_reg;
    assign in_stall = at_last & busy;
    assign accept   = in_valid & ~in_stall;

    imu_fs_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .at_last     (at_last),
        .frame_valid (frame_valid),
        .frame_meta  (frame_meta),
        .words       (words)
    );

    assign rx_in = words[6];
    assign ry_in = words[7] ^ SIGN_BIT;
    assign rz_in = words[8] ^ SIGN_BIT;

    imu_fs_rate_mul u_mul_x (.clk(clk), .in_bits(rx_in), .out_bits(rx_out));
    imu_fs_rate_mul u_mul_y (.clk(clk), .in_bits(ry_in), .out_bits(ry_out));
    imu_fs_rate_mul u_mul_z (.clk(clk), .in_bits(rz_in), .out_bits(rz_out));

    always_comb
    begin
        val_next[0] = words[0];
        val_next[1] = words[1];
        val_next[2] = words[2] ^ SIGN_BIT;
        val_next[3] = words[3];
        val_next[4] = words[4] ^ SIGN_BIT;
        val_next[5] = words[5] ^ SIGN_BIT;
        val_next[6] = rx_out;
        val_next[7] = ry_out;
        val_next[8] = rz_out;
        if (mul_meta_reg.bad)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                val_next[i] = '0;
        end
        mul_valid_next = frame_valid;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (mul_valid_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid)
            mul_meta_reg <= frame_meta;
        if (mul_valid_reg)
        begin
            val_reg    <= val_next;
            status_reg <= mul_meta_reg.bad;
            errors_reg <= mul_meta_reg.errors;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pitch_bits      = val_reg[0];
    assign roll_bits       = val_reg[1];
    assign yaw_bits        = val_reg[2];
    assign accel_x_bits    = val_reg[3];
    assign accel_y_bits    = val_reg[4];
    assign accel_z_bits    = val_reg[5];
    assign rate_x_bits     = val_reg[6];
    assign rate_y_bits     = val_reg[7];
    assign rate_z_bits     = val_reg[8];
    assign frame_status    = status_reg;
    assign checksum_errors = errors_reg;

`ifndef SYNTHESIS
    // Only one frame result is ever in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({frame_valid, mul_valid_reg, out_valid_reg}))
        else $error("more than one frame result in flight");

    a_frame_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |=> mul_valid_reg && out_valid_next)
        else $error("frame result lost before the output register");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status |-> pitch_bits == 32'd0 && rate_z_bits == 32'd0)
        else $error("bad frame carries nonzero values");
`endif

endmodule

/* hdl/imu_fs_parser.sv */
module imu_fs_parser
    import imu_fs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output logic        at_last,
    output logic        frame_valid,
    output frame_meta_t frame_meta,
    output word_t       words [NUM_WORDS]
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] err_reg, err_next;
    logic        fv_reg, fv_next;
    frame_meta_t meta_reg, meta_next;
    word_t       word_reg [NUM_WORDS];
    logic [3:0]  slot;
    logic [7:0]  sum_add;

    assign at_last = (phase_reg == PH_COLLECT)
                  && ({1'b0, pos_reg} + 9'd1 >= 9'(FRAME_BYTES));
    assign slot    = word_slot(pos_reg);
    assign sum_add = sum_reg + rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        fv_next    = 1'b0;
        meta_next  = meta_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_COLLECT:
                begin
                    if (at_last)
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = 8'd0;
                        sum_next   = 8'd0;
                        fv_next    = 1'b1;
                        if (sum_add != 8'd0 && err_reg != 16'hFFFF)
                            err_next = err_reg + 16'd1;
                        meta_next.bad    = (sum_add != 8'd0);
                        meta_next.errors = err_next;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                        sum_next = sum_add;
                    end
                end
                PH_PRE:
                begin
                    if (rx_byte == PRE_B)
                    begin
                        phase_next = PH_COLLECT;
                        pos_next   = 8'd2;
                        sum_next   = PRE_B;
                    end
                    else if (rx_byte != PRE_A)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (rx_byte == PRE_A) ? PH_PRE : PH_HUNT;
                    pos_next   = 8'd0;
                    sum_next   = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            err_reg   <= 16'd0;
            fv_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            err_reg   <= err_next;
            fv_reg    <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
        if (accept && phase_reg == PH_COLLECT && slot != NO_SLOT)
            word_reg[slot] <= {word_reg[slot][23:0], rx_byte};
    end

    assign frame_valid = fv_reg;
    assign frame_meta  = meta_reg;
    assign words       = word_reg;

endmodule

/* hdl/imu_fs_rate_mul.sv */
module imu_fs_rate_mul
    import imu_fs_pkg::*;
(
    input  logic  clk,
    input  word_t in_bits,
    output word_t out_bits
);

    logic        s_in, nan_in, inf_in, zero_in;
    logic [7:0]  e_in, eb_in;
    logic [23:0] m_in;

    logic        s_reg, nan_reg, inf_reg, zero_reg;
    logic [7:0]  eb_reg;
    logic [21:0] pay_reg;
    logic [47:0] p_reg;

    logic [5:0]  lead;
    logic [9:0]  sum_le, exp_base;
    logic        norm;
    logic [4:0]  sh;
    logic [24:0] q, qr;
    logic        guard, sticky, rnd;
    logic [47:0] low_mask;
    logic [32:0] packed_w;

    assign s_in    = in_bits[31];
    assign e_in    = in_bits[30:23];
    assign nan_in  = (e_in == 8'hFF) && (in_bits[22:0] != 23'd0);
    assign inf_in  = (e_in == 8'hFF) && (in_bits[22:0] == 23'd0);
    assign zero_in = (e_in == 8'h00) && (in_bits[22:0] == 23'd0);
    assign m_in    = {e_in != 8'h00, in_bits[22:0]};
    assign eb_in   = (e_in == 8'h00) ? 8'd1 : e_in;

    always_ff @(posedge clk)
    begin
        s_reg    <= s_in;
        nan_reg  <= nan_in;
        inf_reg  <= inf_in;
        zero_reg <= zero_in;
        eb_reg   <= eb_in;
        pay_reg  <= in_bits[21:0];
        p_reg    <= {24'd0, m_in} * {24'd0, RATE_K};
    end

    // Only the top few product bits matter for the lead position; a lower lead
    // comes from a subnormal input and always takes the subnormal shift.
    always_comb
    begin
        lead = 6'd0;
        for (int i = 41; i < 48; i++)
        begin
            if (p_reg[i])
                lead = 6'(i);
        end
    end

    assign sum_le   = {4'd0, lead} + {2'd0, eb_reg};
    assign norm     = (sum_le >= RATE_EXP_ADJ);
    assign exp_base = norm ? (sum_le - RATE_EXP_ADJ) : 10'd0;
    assign sh       = norm ? 5'(lead - 6'd23) : RATE_SUB_SHIFT;
    assign q        = 25'(p_reg >> sh);
    assign guard    = p_reg[6'(sh) - 6'd1];
    assign low_mask = (48'd1 << (sh - 5'd1)) - 48'd1;
    assign sticky   = |(p_reg & low_mask);
    assign rnd      = guard & (sticky | q[0]);
    assign qr       = q + {24'd0, rnd};
    // The hidden bit of a normal result carries into the exponent field.
    assign packed_w = {exp_base, 23'd0} + {8'd0, qr};

    always_comb
    begin
        if (nan_reg)
            out_bits = {s_reg, 8'hFF, 1'b1, pay_reg};
        else if (inf_reg)
            out_bits = {s_reg, 8'hFF, 23'd0};
        else if (zero_reg)
            out_bits = {s_reg, 31'd0};
        else if (packed_w >= 33'h07F80_0000)
            out_bits = {s_reg, 8'hFF, 23'd0};
        else
            out_bits = {s_reg, packed_w[30:0]};
    end

endmodule
